/* rtl/core/mqtt_publish_header_parser_top_defines.svh */
// Assertion macros for the MQTT PUBLISH header parser.
// Included by the top level; no other dependencies.
`ifndef MQTT_PUBLISH_HEADER_PARSER_TOP_DEFINES_SVH
`define MQTT_PUBLISH_HEADER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MPHP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mphp assertion failed");

// Next-cycle implication, disabled during reset.
`define MPHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mphp assertion failed");

`endif

/* rtl/core/mphp_pkg.sv */
// Shared types and constants for the MQTT PUBLISH header parser.
// No dependencies; imported by every module of the block.
package mphp_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } mphp_req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [2:0]  byte_kind;
      logic        done_res;
      logic [1:0]  status;
      logic [1:0]  qos_level;
      logic [15:0] packet_ident;
      logic [15:0] topic_size;
      logic [15:0] payload_length;
      logic [27:0] rem_length;
      logic        ack_needed;
   } mphp_rsp_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       is_publish;
      logic [1:0] qos;
      logic       more;
   } mphp_beat_type;

   typedef struct packed {
      logic avail;
      logic full;
   } mphp_qstat_type;

   typedef enum logic [6:0] {
      PH_HEADER  = 7'b0000001,
      PH_LENGTH  = 7'b0000010,
      PH_TOPLEN  = 7'b0000100,
      PH_TOPIC   = 7'b0001000,
      PH_IDENT   = 7'b0010000,
      PH_PAYLOAD = 7'b0100000,
      PH_IGNORE  = 7'b1000000
   } mphp_phase_type;

   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_LENGTH  = 3'd1;
   localparam logic [2:0] KIND_TOPLEN  = 3'd2;
   localparam logic [2:0] KIND_TOPIC   = 3'd3;
   localparam logic [2:0] KIND_IDENT   = 3'd4;
   localparam logic [2:0] KIND_PAYLOAD = 3'd5;
   localparam logic [2:0] KIND_IGNORE  = 3'd6;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NOT_PUBLISH = 2'd1;
   localparam logic [1:0] ST_TRUNCATED   = 2'd2;
   localparam logic [1:0] ST_LONG_LENGTH = 2'd3;

   localparam logic [3:0]  PUBLISH_TYPE = 4'h3;
   localparam logic [15:0] FIELD_BYTES  = 16'd2;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
   localparam int unsigned ACCUM_W      = 28;

endpackage

/* rtl/core/mphp_front.sv */
// Input side: accepts request beats and classifies each byte.
// Depends on mphp_pkg; feeds mphp_fifo.
module mphp_front import mphp_pkg::*; (
   input  logic           req_valid,
   output logic           req_stall,
   input  mphp_req_type   req_data,
   input  mphp_qstat_type qstat,
   output logic           push,
   output mphp_beat_type  push_beat
);

   assign req_stall = qstat.full;
   assign push      = req_valid & ~qstat.full;

   always_comb begin
      push_beat.data       = req_data.in_byte;
      push_beat.last       = req_data.last_byte;
      push_beat.is_publish = (req_data.in_byte[7:4] == PUBLISH_TYPE);
      push_beat.qos        = req_data.in_byte[2:1];
      push_beat.more       = req_data.in_byte[7];
   end

endmodule

/* rtl/core/mphp_fifo.sv */
// Short beat queue between the classifier and the parser.
// Depends on mphp_pkg.
module mphp_fifo import mphp_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  mphp_beat_type  push_beat,
   input  logic           pop,
   output mphp_qstat_type qstat,
   output mphp_beat_type  head_beat
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   mphp_beat_type   mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign qstat.avail = (count_ff != '0);
   assign qstat.full  = (count_ff == CW'(DEPTH));
   assign head_beat   = mem_ff[rd_ptr_ff];

endmodule

/* rtl/core/mphp_back.sv */
// Parser: phase machine over queued beats and the response register.
// Depends on mphp_pkg; fed by mphp_fifo.
module mphp_back import mphp_pkg::*; #(
   parameter int unsigned LEN_FIELD_MAX_BYTES = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  mphp_qstat_type qstat,
   input  mphp_beat_type  head_beat,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output mphp_rsp_type   rsp_data
);

   localparam int unsigned LCW = $clog2(LEN_FIELD_MAX_BYTES + 1);

   mphp_phase_type    phase_ff, phase_in, phase_after;
   logic [1:0]        qos_ff, qos_in;
   logic [ACCUM_W-1:0] accum_ff, accum_in;
   logic [LCW-1:0]    lcnt_ff, lcnt_in, lcnt_inc;
   logic [15:0]       toplen_ff, toplen_in;
   logic [15:0]       fc_ff, fc_in, fc_inc;
   logic [15:0]       ident_ff, ident_in;
   logic [15:0]       pay_ff, pay_in;
   logic [1:0]        err_ff, err_in;
   logic [4:0]        len_shift;
   logic [2:0]        kind;
   logic              rsp_valid_ff;
   mphp_rsp_type      rsp_ff, rsp_in;
   logic              advance;

   assign advance = qstat.avail & (~rsp_valid_ff | ~rsp_stall);
   assign pop     = advance;

   always_comb begin
      phase_in    = phase_ff;
      qos_in      = qos_ff;
      accum_in    = accum_ff;
      lcnt_in     = lcnt_ff;
      toplen_in   = toplen_ff;
      fc_in       = fc_ff;
      ident_in    = ident_ff;
      pay_in      = pay_ff;
      err_in      = err_ff;
      kind        = KIND_IGNORE;
      fc_inc      = fc_ff + 16'd1;
      lcnt_inc    = lcnt_ff + 1'b1;
      len_shift   = 5'(lcnt_ff) * 5'd7;
      phase_after = (qos_ff != 2'd0) ? PH_IDENT : PH_PAYLOAD;
      case (phase_ff)
         PH_HEADER: begin
            kind = KIND_HEADER;
            if (!head_beat.is_publish) begin
               err_in   = ST_NOT_PUBLISH;
               phase_in = PH_IGNORE;
            end else begin
               qos_in   = head_beat.qos;
               phase_in = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            kind     = KIND_LENGTH;
            accum_in = accum_ff | (ACCUM_W'(head_beat.data[6:0]) << len_shift);
            lcnt_in  = lcnt_inc;
            if (head_beat.more) begin
               if (lcnt_inc >= LCW'(LEN_FIELD_MAX_BYTES)) begin
                  err_in   = ST_LONG_LENGTH;
                  phase_in = PH_IGNORE;
               end
            end else begin
               fc_in    = '0;
               phase_in = PH_TOPLEN;
            end
         end
         PH_TOPLEN: begin
            kind      = KIND_TOPLEN;
            toplen_in = {toplen_ff[7:0], head_beat.data};
            fc_in     = fc_inc;
            if (fc_inc >= FIELD_BYTES) begin
               fc_in    = '0;
               phase_in = (toplen_in != 16'd0) ? PH_TOPIC : phase_after;
            end
         end
         PH_TOPIC: begin
            kind  = KIND_TOPIC;
            fc_in = fc_inc;
            if (fc_inc >= toplen_ff) begin
               fc_in    = '0;
               phase_in = phase_after;
            end
         end
         PH_IDENT: begin
            kind     = KIND_IDENT;
            ident_in = {ident_ff[7:0], head_beat.data};
            fc_in    = fc_inc;
            if (fc_inc >= FIELD_BYTES) begin
               fc_in    = '0;
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            kind = KIND_PAYLOAD;
            if (pay_ff != COUNT_MAX) begin
               pay_in = pay_ff + 16'd1;
            end
         end
         default: begin
            kind = KIND_IGNORE;
         end
      endcase

      rsp_in           = '0;
      rsp_in.out_byte  = head_beat.data;
      rsp_in.byte_kind = kind;
      if (head_beat.last) begin
         rsp_in.done_res = 1'b1;
         if (err_in != ST_OK) begin
            rsp_in.status = err_in;
         end else if (phase_in == PH_PAYLOAD) begin
            rsp_in.status = ST_OK;
         end else begin
            rsp_in.status = ST_TRUNCATED;
         end
         if (rsp_in.status == ST_OK) begin
            rsp_in.qos_level      = qos_in;
            rsp_in.packet_ident   = ident_in;
            rsp_in.topic_size     = toplen_in;
            rsp_in.payload_length = pay_in;
            rsp_in.rem_length     = accum_in;
            rsp_in.ack_needed     = (ident_in != 16'd0);
         end
         phase_in  = PH_HEADER;
         qos_in    = '0;
         accum_in  = '0;
         lcnt_in   = '0;
         toplen_in = '0;
         fc_in     = '0;
         ident_in  = '0;
         pay_in    = '0;
         err_in    = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         qos_ff       <= '0;
         accum_ff     <= '0;
         lcnt_ff      <= '0;
         toplen_ff    <= '0;
         fc_ff        <= '0;
         ident_ff     <= '0;
         pay_ff       <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff  <= phase_in;
            qos_ff    <= qos_in;
            accum_ff  <= accum_in;
            lcnt_ff   <= lcnt_in;
            toplen_ff <= toplen_in;
            fc_ff     <= fc_in;
            ident_ff  <= ident_in;
            pay_ff    <= pay_in;
            err_ff    <= err_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/mqtt_publish_header_parser_top.sv */
// Top level of the MQTT PUBLISH header parser: classifier, beat queue, parser.
// Depends on mphp_pkg, mphp_front, mphp_fifo, mphp_back and the defines header.
//
//   port group | dir | handshake           | payload
//   req_       | in  | req_valid/req_stall | mphp_req_type: in_byte, last_byte
//   rsp_       | out | rsp_valid/rsp_stall | mphp_rsp_type: byte echo, kind, summary
//
// One byte per cycle sustained while not stalled; one response beat per request beat.
// A byte passes the queue write, then the parser phase register and response register.
// The parse phase register loop sets the rate: one byte enters it per cycle when not stalled.
// Synchronous reset clears the queue pointers, phase machine and response valid.
// rsp_stall holds the response register; the QUEUE_DEPTH-beat queue keeps req_ open until it fills.
`include "mqtt_publish_header_parser_top_defines.svh"
module mqtt_publish_header_parser_top import mphp_pkg::*; #(
   parameter int unsigned LEN_FIELD_MAX_BYTES = 4,
   parameter int unsigned QUEUE_DEPTH         = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  mphp_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output mphp_rsp_type rsp_data
);

   mphp_qstat_type qstat;
   mphp_beat_type  push_beat;
   mphp_beat_type  head_beat;
   logic           push;
   logic           pop;
   logic           rsp_mid;
   logic           mid_summary_clear;
   logic           ack_ok;
   logic           rsp_done_payload;

   mphp_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .qstat     (qstat),
      .push      (push),
      .push_beat (push_beat)
   );

   mphp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .pop       (pop),
      .qstat     (qstat),
      .head_beat (head_beat)
   );

   mphp_back #(
      .LEN_FIELD_MAX_BYTES (LEN_FIELD_MAX_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .head_beat (head_beat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_mid           = rsp_valid && !rsp_data.done_res;
   assign mid_summary_clear = (rsp_data.status == ST_OK) && (rsp_data.packet_ident == 16'd0)
                              && (rsp_data.rem_length == 28'd0)
                              && (rsp_data.payload_length == 16'd0);
   assign ack_ok            = (rsp_data.status == ST_OK) && (rsp_data.packet_ident != 16'd0);
   assign rsp_done_payload  = rsp_valid && rsp_data.done_res
                              && (rsp_data.byte_kind == KIND_PAYLOAD);

   `MPHP_ASSERT_NOW(a_summary_zero_mid, clock, reset, rsp_mid, mid_summary_clear)
   `MPHP_ASSERT_NOW(a_ack_ok, clock, reset, rsp_valid && rsp_data.ack_needed, ack_ok)
   `MPHP_ASSERT_NOW(a_payload_done_ok, clock, reset, rsp_done_payload, rsp_data.status == ST_OK)
   `MPHP_ASSERT_NEXT(a_queue_drains, clock, reset, qstat.avail && !rsp_valid, rsp_valid)

endmodule

/* tb/mqtt_publish_header_parser_top_tb.sv */
// Self-checking bench for the MQTT PUBLISH header parser: byte streams in, echoed beats out.
// Each beat is predicted by a scoreboard class and checked field by field on the way out.
// Depends on mphp_pkg and mqtt_publish_header_parser_top only.
module mqtt_publish_header_parser_top_tb import mphp_pkg::*;;

   localparam int LEN_BYTES_MAX  = 4;
   localparam int RANDOM_BYTES   = 1260;
   localparam int DRAIN_EVERY    = 40;
   localparam int REPORT_LINES   = 30;

   typedef enum int {IDLE_NONE, IDLE_NORMAL, IDLE_HEAVY, IDLE_LIGHT} idle_level_type;
   typedef logic [7:0] byte_q_type[$];

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   mphp_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   mphp_rsp_type rsp_data;

   idle_level_type idle_level = IDLE_NONE;

   class publish_scoreboard;
      mphp_phase_type phase;
      logic [1:0]     qos;
      logic [27:0]    len_accum;
      logic [2:0]     len_count;
      logic [15:0]    topic_total;
      logic [15:0]    field_cnt;
      logic [15:0]    ident;
      logic [15:0]    payload_cnt;
      logic [1:0]     err;
      mphp_rsp_type   expected_beats[$];
      int             errors;
      int             beats_checked;
      int             buffers_done;
      int             status_seen[4];

      function new();
         errors = 0;
         beats_checked = 0;
         buffers_done = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         reset_parse();
      endfunction

      function void reset_parse();
         phase       = PH_HEADER;
         qos         = '0;
         len_accum   = '0;
         len_count   = '0;
         topic_total = '0;
         field_cnt   = '0;
         ident       = '0;
         payload_cnt = '0;
         err         = ST_OK;
      endfunction

      function mphp_phase_type after_topic();
         return (qos != 2'd0) ? PH_IDENT : PH_PAYLOAD;
      endfunction

      function void note_byte(mphp_req_type item);
         logic [7:0]   b;
         logic [2:0]   kind;
         logic [1:0]   st;
         logic [31:0]  term;
         mphp_rsp_type exp;
         b = item.in_byte;
         case (phase)
            PH_HEADER: begin
               kind = KIND_HEADER;
               if (b[7:4] != PUBLISH_TYPE) begin
                  err   = ST_NOT_PUBLISH;
                  phase = PH_IGNORE;
               end else begin
                  qos   = b[2:1];
                  phase = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               kind = KIND_LENGTH;
               if (len_count < 3'd4) begin
                  term      = 32'(b[6:0]) << (7 * len_count);
                  len_accum = len_accum + term[27:0];
               end
               len_count = len_count + 3'd1;
               if (b[7]) begin
                  if (int'(len_count) >= LEN_BYTES_MAX) begin
                     err   = ST_LONG_LENGTH;
                     phase = PH_IGNORE;
                  end
               end else begin
                  field_cnt = '0;
                  phase     = PH_TOPLEN;
               end
            end
            PH_TOPLEN: begin
               kind        = KIND_TOPLEN;
               topic_total = {topic_total[7:0], b};
               field_cnt   = field_cnt + 16'd1;
               if (field_cnt >= FIELD_BYTES) begin
                  field_cnt = '0;
                  phase     = (topic_total != 16'd0) ? PH_TOPIC : after_topic();
               end
            end
            PH_TOPIC: begin
               kind      = KIND_TOPIC;
               field_cnt = field_cnt + 16'd1;
               if (field_cnt >= topic_total) begin
                  field_cnt = '0;
                  phase     = after_topic();
               end
            end
            PH_IDENT: begin
               kind      = KIND_IDENT;
               ident     = {ident[7:0], b};
               field_cnt = field_cnt + 16'd1;
               if (field_cnt >= FIELD_BYTES) begin
                  field_cnt = '0;
                  phase     = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               kind = KIND_PAYLOAD;
               if (payload_cnt < COUNT_MAX) payload_cnt = payload_cnt + 16'd1;
            end
            default: kind = KIND_IGNORE;
         endcase

         exp           = '0;
         exp.out_byte  = b;
         exp.byte_kind = kind;
         if (item.last_byte) begin
            if (err != ST_OK) st = err;
            else if (phase == PH_PAYLOAD) st = ST_OK;
            else st = ST_TRUNCATED;
            exp.done_res = 1'b1;
            exp.status   = st;
            if (st == ST_OK) begin
               exp.qos_level      = qos;
               exp.packet_ident   = ident;
               exp.topic_size     = topic_total;
               exp.payload_length = payload_cnt;
               exp.rem_length     = len_accum;
               exp.ack_needed     = (ident != 16'd0);
            end
            status_seen[st]++;
            buffers_done++;
            reset_parse();
         end
         expected_beats.push_back(exp);
      endfunction

      task report(string what, logic [27:0] got, logic [27:0] want);
         errors++;
         if (errors <= REPORT_LINES)
            $display("mismatch at beat %0d, %s: got 0x%0h, expected 0x%0h",
                     beats_checked, what, got, want);
      endtask

      task compare(string what, logic [27:0] got, logic [27:0] want);
         if (got !== want) report(what, got, want);
      endtask

      task check_beat(mphp_rsp_type got);
         mphp_rsp_type exp;
         if (expected_beats.size() == 0) begin
            report("unexpected beat, out_byte", got.out_byte, '0);
         end else begin
            exp = expected_beats.pop_front();
            compare("out_byte", got.out_byte, exp.out_byte);
            compare("byte_kind", got.byte_kind, exp.byte_kind);
            compare("done_res", got.done_res, exp.done_res);
            compare("status", got.status, exp.status);
            compare("qos_level", got.qos_level, exp.qos_level);
            compare("packet_ident", got.packet_ident, exp.packet_ident);
            compare("topic_size", got.topic_size, exp.topic_size);
            compare("payload_length", got.payload_length, exp.payload_length);
            compare("rem_length", got.rem_length, exp.rem_length);
            compare("ack_needed", got.ack_needed, exp.ack_needed);
         end
         beats_checked++;
      endtask
   endclass

   publish_scoreboard sb = new();

   mqtt_publish_header_parser_top #(
      .LEN_FIELD_MAX_BYTES(LEN_BYTES_MAX)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap(idle_level_type level);
      int r;
      r = $urandom_range(0, 99);
      case (level)
         IDLE_NONE:  return 0;
         IDLE_LIGHT: return (r < 95) ? 0 : $urandom_range(1, 2);
         IDLE_HEAVY: begin
            if (r < 30) return 0;
            return (r < 80) ? $urandom_range(1, 4) : $urandom_range(5, 24);
         end
         default: begin
            if (r < 65) return 0;
            return (r < 93) ? $urandom_range(1, 3) : $urandom_range(4, 24);
         end
      endcase
   endfunction

   function automatic idle_level_type pick_level();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return IDLE_NONE;
      if (r < 80) return IDLE_NORMAL;
      return IDLE_HEAVY;
   endfunction

   task automatic send_beat(logic [7:0] b, logic lst);
      int gap;
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, last_byte: lst};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(req_data);
      gap = pick_gap(idle_level);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_frame(byte_q_type frame);
      foreach (frame[i]) send_beat(frame[i], i == frame.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_beats.size() != 0) @(posedge clock);
   endtask

   initial begin : rsp_side
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_beat(rsp_data);
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            hold = pick_gap(idle_level);
         end
      end
   end

   initial begin : stimulus
      byte_q_type  frame;
      int          bytes_sent;
      int          frames_sent;
      int          pick;
      int          n;
      int          topic_put;
      logic [1:0]  qos;
      logic [15:0] tlen;

      bytes_sent  = 0;
      frames_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      idle_level = pick_level();
      frame = '{8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF};
      send_frame(frame);
      frame = '{8'h30, 8'h01, 8'h00, 8'h01, 8'h80};
      send_frame(frame);
      idle_level = pick_level();
      frame = '{8'h32, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34, 8'h00};
      send_frame(frame);
      frame = '{8'h00, 8'hFF};
      send_frame(frame);
      frame = '{8'h34, 8'h80, 8'h80, 8'h80, 8'h80};
      send_frame(frame);
      frame = '{8'h32};
      send_frame(frame);
      wait_drained();

      // four-byte length field and QoS three, then identifier and a short payload
      idle_level = IDLE_LIGHT;
      frame = '{8'h36, 8'h85, 8'h80, 8'h88, 8'h01, 8'h00, 8'h02, 8'h61, 8'h62,
                8'h5A, 8'hA5, 8'h01, 8'h02, 8'h03};
      send_frame(frame);
      wait_drained();

      while (bytes_sent < RANDOM_BYTES) begin
         idle_level = pick_level();
         pick = $urandom_range(0, 99);
         frame = {};
         if (pick < 12) begin
            n = $urandom_range(1, 6);
            repeat (n) frame.push_back(8'($urandom));
         end else begin
            qos = 2'($urandom);
            frame.push_back({PUBLISH_TYPE, 1'($urandom), qos, 1'($urandom)});
            if (pick < 25) begin
               n = $urandom_range(LEN_BYTES_MAX, LEN_BYTES_MAX + 2);
               repeat (n) frame.push_back(8'h80 | 8'($urandom));
               repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
            end else begin
               n = $urandom_range(1, LEN_BYTES_MAX);
               for (int i = 0; i < n; i++) frame.push_back({i != n - 1, 7'($urandom)});
               tlen = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
               frame.push_back(tlen[15:8]);
               frame.push_back(tlen[7:0]);
               topic_put = (tlen > 16'd8) ? $urandom_range(0, 8) : int'(tlen);
               repeat (topic_put) frame.push_back(8'($urandom));
               if (topic_put == int'(tlen)) begin
                  if (qos != 2'd0) begin
                     frame.push_back(8'($urandom));
                     frame.push_back(8'($urandom));
                  end
                  repeat ($urandom_range(0, 8)) frame.push_back(8'($urandom));
               end
            end
            if ($urandom_range(0, 4) == 0 && frame.size() > 1)
               frame = frame[0:$urandom_range(0, frame.size() - 2)];
         end
         send_frame(frame);
         bytes_sent += frame.size();
         frames_sent++;
         if (frames_sent % DRAIN_EVERY == 0) wait_drained();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      $display("checked %0d beats over %0d buffers, with stalls on both sides and edge frames",
               sb.beats_checked, sb.buffers_done);
      $display("final status: %0d ok, %0d not publish, %0d truncated, %0d long length field",
               sb.status_seen[ST_OK], sb.status_seen[ST_NOT_PUBLISH],
               sb.status_seen[ST_TRUNCATED], sb.status_seen[ST_LONG_LENGTH]);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #300000000;
      $display("timeout with %0d beats outstanding", sb.expected_beats.size());
      $display("Some tests failed");
      $finish;
   end

endmodule

/* mqtt_publish_header_parser_top.f */
+incdir+rtl/core
rtl/core/mphp_pkg.sv
rtl/core/mphp_front.sv
rtl/core/mphp_fifo.sv
rtl/core/mphp_back.sv
rtl/core/mqtt_publish_header_parser_top.sv
tb/mqtt_publish_header_parser_top_tb.sv
